>>> rtl/psf_pkg.sv
`default_nettype none

package psf_pkg;

    localparam int DATA_W = 10;

    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_READ_FIRST  = 2'd1,
        OP_READ_SECOND = 2'd2,
        OP_READ_THIRD  = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] Q_FIRST  = 2'd0;
    localparam logic [1:0] Q_SECOND = 2'd1;
    localparam logic [1:0] Q_THIRD  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [DATA_W-1:0]   write_value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [1:0]          chosen_queue;
        logic [1:0]          status;
    } t_res;

    typedef struct packed {
        logic go;     // launch the request on the input ports
        logic resp;   // result registers hold a finished request
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/psf_fifo.sv
`default_nettype none

module psf_fifo #(
    parameter int DEPTH = 8,
    parameter int W     = 10
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic         i_pop,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    output logic              o_empty,
    output logic [W-1:0]      o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [W-1:0]  r_rdata;
    logic [PW-1:0] r_head, r_tail, n_head, n_tail;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_rdata;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_pop) begin
            n_head  = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

endmodule

`default_nettype wire

>>> rtl/psf_datapath.sv
`default_nettype none

module psf_datapath
    import psf_pkg::*;
#(
    parameter int FIRST_DEPTH  = 32,
    parameter int SECOND_DEPTH = 16,
    parameter int THIRD_DEPTH  = 8,
    parameter int VALUE_WIDTH  = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_req i_req,
    output t_res      o_res
);

    // stored width: the request field carries at most DATA_W bits
    localparam int SW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

    logic [2:0]    full, empty, push, pop;
    logic [SW-1:0] wdata;
    logic [SW-1:0] rdata [3];

    logic [1:0]    r_chosen, n_chosen;
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_rsel, n_rsel;
    logic          r_rd_ok, n_rd_ok;
    logic [SW-1:0] sel_data;

    assign wdata = i_req.write_value[SW-1:0];

    psf_fifo #(.DEPTH(FIRST_DEPTH), .W(SW)) u_first (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push[0]), .i_pop(pop[0]),
        .i_wdata(wdata), .o_full(full[0]), .o_empty(empty[0]), .o_rdata(rdata[0])
    );

    psf_fifo #(.DEPTH(SECOND_DEPTH), .W(SW)) u_second (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push[1]), .i_pop(pop[1]),
        .i_wdata(wdata), .o_full(full[1]), .o_empty(empty[1]), .o_rdata(rdata[1])
    );

    psf_fifo #(.DEPTH(THIRD_DEPTH), .W(SW)) u_third (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push[2]), .i_pop(pop[2]),
        .i_wdata(wdata), .o_full(full[2]), .o_empty(empty[2]), .o_rdata(rdata[2])
    );

    always_comb begin
        push     = '0;
        pop      = '0;
        n_chosen = r_chosen;
        n_status = r_status;
        n_rsel   = r_rsel;
        n_rd_ok  = r_rd_ok;
        if (i_cmd.go) begin
            n_chosen = Q_FIRST;
            n_status = ST_DONE;
            n_rd_ok  = 1'b0;
            n_rsel   = Q_FIRST;
            unique case (i_req.opcode)
                OP_WRITE: begin
                    // spill in priority order
                    if (!full[0]) begin
                        push[0] = 1'b1;
                    end else if (!full[1]) begin
                        push[1]  = 1'b1;
                        n_chosen = Q_SECOND;
                    end else if (!full[2]) begin
                        push[2]  = 1'b1;
                        n_chosen = Q_THIRD;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                OP_READ_FIRST: begin
                    n_rsel = Q_FIRST;
                end
                OP_READ_SECOND: begin
                    n_rsel = Q_SECOND;
                end
                OP_READ_THIRD: begin
                    n_rsel = Q_THIRD;
                end
                default: begin
                    n_rsel = Q_FIRST;
                end
            endcase
            if (i_req.opcode != OP_WRITE) begin
                if (empty[n_rsel]) begin
                    n_status = ST_EMPTY;
                end else begin
                    pop[n_rsel] = 1'b1;
                    n_rd_ok     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chosen <= n_chosen;
        r_status <= n_status;
        r_rsel   <= n_rsel;
        r_rd_ok  <= n_rd_ok;
    end

    always_comb begin
        case (r_rsel)
            Q_SECOND: sel_data = rdata[1];
            Q_THIRD:  sel_data = rdata[2];
            default:  sel_data = rdata[0];
        endcase
    end

    assign o_res.read_value   = r_rd_ok ? DATA_W'(sel_data) : '0;
    assign o_res.chosen_queue = r_chosen;
    assign o_res.status       = r_status;

endmodule

`default_nettype wire

>>> rtl/psf_ctrl.sv
`default_nettype none

module psf_ctrl
    import psf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.go   = 1'b0;
        o_cmd.resp = 1'b0;
        o_busy     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.go = 1'b1;
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                o_cmd.resp = 1'b1;
                o_busy     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/priority_spill_triple_fifo_unit.sv
// channel   | ports                  | handshake
// ----------+------------------------+------------------------------------------
// request   | start, busy, i_req     | taken on the edge with start=1, busy=0
// result    | o_valid, o_res         | o_valid high for one cycle per request
//
// The issue cycle performs the push or pop, and the result follows in the
// next cycle, set by the registered FIFO memory read. busy is high during
// that result cycle, so no new request is taken while a result is shown.
// Reset (synchronous, active low) clears the FIFO pointers and counts; the
// stores are not cleared. The receiver cannot stall the result.
`default_nettype none

module priority_spill_triple_fifo_unit
    import psf_pkg::*;
#(
    parameter int FIRST_DEPTH  = 32,
    parameter int SECOND_DEPTH = 16,
    parameter int THIRD_DEPTH  = 8,
    parameter int VALUE_WIDTH  = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_res      o_res
);

    t_cmd cmd;

    psf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    psf_datapath #(
        .FIRST_DEPTH  (FIRST_DEPTH),
        .SECOND_DEPTH (SECOND_DEPTH),
        .THIRD_DEPTH  (THIRD_DEPTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_res   (o_res)
    );

    assign o_valid = cmd.resp;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted request produced no result");

    a_single_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held beyond the result cycle");

    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == ST_FULL) |->
            (o_res.chosen_queue == Q_FIRST && o_res.read_value == '0))
        else $error("rejected write carries nonzero fields");

    a_full_only_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.opcode != OP_WRITE) |=>
            (o_res.status != ST_FULL && o_res.chosen_queue == Q_FIRST))
        else $error("read request reported a write outcome");
`endif

endmodule

`default_nettype wire
